[rtl/binary_delta_encoder_defines.svh]
// Assertion macros shared by the checker.
`ifndef BINARY_DELTA_ENCODER_DEFINES_SVH
`define BINARY_DELTA_ENCODER_DEFINES_SVH

// Implication checked on every edge out of reset.
`define BDE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bde check failed");

// Next-cycle implication checked on every edge out of reset.
`define BDE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bde check failed");

`endif

[rtl/bde_pkg.sv]
package bde_pkg;

  localparam int BLOCK_LEN    = 16;
  localparam int SAMPLE_STEP  = 16;
  localparam int MAX_SLOTS    = 4096;
  localparam int PROBE_LIMIT  = 8;
  localparam int BASE_DEPTH   = 4096;
  localparam int TARGET_DEPTH = 4096;
  localparam int OUT_CAP      = 2 * TARGET_DEPTH + 32;

  localparam int AW   = $clog2(BASE_DEPTH);
  localparam int TW   = $clog2(TARGET_DEPTH);
  localparam int CW   = 17;
  localparam int SW   = $clog2(MAX_SLOTS);
  localparam int OW   = $clog2(OUT_CAP);
  localparam int OCW  = OW + 1;
  localparam int BLW  = $clog2(BLOCK_LEN + 1);
  localparam int PLW  = $clog2(PROBE_LIMIT + 1);

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [16:0] CHUNK_MAX  = 17'h10000;
  localparam logic [6:0]  INS_MAX    = 7'd127;
  localparam logic [CW-1:0] SLOTS_MIN = CW'(1024);

  typedef enum logic [1:0] {
    FN_LOAD_BASE   = 2'd0,
    FN_LOAD_TARGET = 2'd1,
    FN_FINISH      = 2'd2,
    FN_PULL        = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_job;
    logic ld_base;
    logic ld_target;
    logic enc_start;
    logic pull;
  } bde_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic enc_busy;
    logic overflow;
    logic has_byte;
    logic last_byte;
  } bde_sts_t;

endpackage

[rtl/bde_datapath.sv]
module bde_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bde_pkg::bde_cmd_t     cmd,
  input  logic [7:0]            data_byte,
  output bde_pkg::bde_sts_t     sts,
  output logic [7:0]            rd_byte
);

  localparam int AW  = bde_pkg::AW;
  localparam int TW  = bde_pkg::TW;
  localparam int CW  = bde_pkg::CW;
  localparam int SW  = bde_pkg::SW;
  localparam int OW  = bde_pkg::OW;
  localparam int OCW = bde_pkg::OCW;
  localparam int BLW = bde_pkg::BLW;
  localparam int PLW = bde_pkg::PLW;

  typedef enum logic [24:0] {
    E_IDLE    = 25'd1 << 0,
    E_VARINT  = 25'd1 << 1,
    E_CLR     = 25'd1 << 2,
    E_BH_RD   = 25'd1 << 3,
    E_BH_ACC  = 25'd1 << 4,
    E_BINS_RD = 25'd1 << 5,
    E_BINS_CK = 25'd1 << 6,
    E_SCAN    = 25'd1 << 7,
    E_TH_RD   = 25'd1 << 8,
    E_TH_ACC  = 25'd1 << 9,
    E_PR_RD   = 25'd1 << 10,
    E_PR_CK   = 25'd1 << 11,
    E_CMP_RD  = 25'd1 << 12,
    E_CMP_CK  = 25'd1 << 13,
    E_DECIDE  = 25'd1 << 14,
    E_INS_HD  = 25'd1 << 15,
    E_INS_RD  = 25'd1 << 16,
    E_INS_WR  = 25'd1 << 17,
    E_CP_HD   = 25'd1 << 18,
    E_CP_FLD  = 25'd1 << 19,
    E_TAIL    = 25'd1 << 20,
    E_MULT    = 25'd1 << 21,
    E_DONE    = 25'd1 << 22,
    E_WIPE    = 25'd1 << 23,
    E_BINS_WR = 25'd1 << 24
  } enc_state_t;

  logic [7:0]  base_mem [bde_pkg::BASE_DEPTH];
  logic [7:0]  targ_mem [bde_pkg::TARGET_DEPTH];
  logic [7:0]  out_mem  [bde_pkg::OUT_CAP];
  // {hash[31:0], offset[12:0]}; a zero hash marks a free slot
  logic [44:0] tab_mem  [bde_pkg::MAX_SLOTS];
  logic [44:0] tab_rd_r;
  logic [7:0]  base_rd_r, targ_rd_r;

  logic [CW-1:0]  base_cnt_r, targ_cnt_r;
  logic           ovf_r;
  logic [OCW-1:0] out_len_r, out_pos_r;

  enc_state_t st_r, ret_r;
  logic [CW-1:0]  slots_r, off_r, scan_r, lit_r, src_r, best_r, best_off_r;
  logic [CW-1:0]  len_r, cand_r, ins_end_r;
  logic [16:0]    run_r;
  logic [31:0]    h_r, cur_h_r, prod_r;
  logic [BLW-1:0] bi_r;
  logic [PLW-1:0] pi_r;
  logic [CW-1:0]  var_r;
  logic           var_sel_r;
  logic [6:0]     ins_cnt_r;
  logic [7:0]     fld_r [7];
  logic [2:0]     fld_n_r, fld_i_r;
  logic           h_for_tgt_r;

  logic           wr_en;
  logic [7:0]     wr_byte;
  logic [SW-1:0]  slot_idx;
  logic [16:0]    chunk;
  logic [SW-1:0]  mask;

  assign mask     = SW'(slots_r - 1'b1);
  assign slot_idx = SW'(h_r + CW'(pi_r)) & mask;
  assign chunk    = (run_r > bde_pkg::CHUNK_MAX) ? bde_pkg::CHUNK_MAX : run_r;

  // loads
  always_ff @(posedge clk) begin
    if (cmd.ld_base && !cmd.clr_job && base_cnt_r < CW'(bde_pkg::BASE_DEPTH))
      base_mem[AW'(base_cnt_r)] <= data_byte;
    if (cmd.ld_base && cmd.clr_job) base_mem[0] <= data_byte;
    if (cmd.ld_target && !cmd.clr_job && targ_cnt_r < CW'(bde_pkg::TARGET_DEPTH))
      targ_mem[TW'(targ_cnt_r)] <= data_byte;
    if (cmd.ld_target && cmd.clr_job) targ_mem[0] <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cnt_r <= '0;
      targ_cnt_r <= '0;
      ovf_r      <= 1'b0;
    end else if (cmd.clr_job) begin
      base_cnt_r <= {{(CW-1){1'b0}}, cmd.ld_base};
      targ_cnt_r <= {{(CW-1){1'b0}}, cmd.ld_target};
      ovf_r      <= 1'b0;
    end else if (cmd.ld_base) begin
      if (base_cnt_r < CW'(bde_pkg::BASE_DEPTH)) base_cnt_r <= base_cnt_r + 1'b1;
      else ovf_r <= 1'b1;
    end else if (cmd.ld_target) begin
      if (targ_cnt_r < CW'(bde_pkg::TARGET_DEPTH)) targ_cnt_r <= targ_cnt_r + 1'b1;
      else ovf_r <= 1'b1;
    end
  end

  // output buffer
  always_ff @(posedge clk) begin
    if (wr_en) out_mem[OW'(out_len_r)] <= wr_byte;
    rd_byte <= out_mem[OW'(out_pos_r)];
  end

  assign sts.enc_busy  = (st_r != E_IDLE) && (st_r != E_DONE);
  assign sts.overflow  = ovf_r;
  assign sts.has_byte  = out_pos_r < out_len_r;
  assign sts.last_byte = (out_pos_r + 1'b1) == out_len_r;

  // encoder sequencer
  always_ff @(posedge clk) begin
    wr_en   <= 1'b0;
    wr_byte <= '0;
    if (!rst_n) begin
      st_r      <= E_IDLE;
      out_len_r <= '0;
      out_pos_r <= '0;
    end else if (cmd.clr_job) begin
      st_r      <= E_IDLE;
      out_len_r <= '0;
      out_pos_r <= '0;
    end else begin
      if (wr_en && out_len_r < OCW'(bde_pkg::OUT_CAP)) out_len_r <= out_len_r + 1'b1;
      if (cmd.pull) out_pos_r <= out_pos_r + 1'b1;
      case (st_r)
        E_IDLE: if (cmd.enc_start) begin
          out_len_r <= '0;
          out_pos_r <= '0;
          if (!ovf_r) begin
            var_r <= base_cnt_r; var_sel_r <= 1'b0; st_r <= E_VARINT;
          end else st_r <= E_DONE;
        end
        E_VARINT: begin
          wr_en <= 1'b1;
          if (var_r[CW-1:7] != '0) begin
            wr_byte <= {1'b1, var_r[6:0]}; var_r <= var_r >> 7;
          end else begin
            wr_byte <= {1'b0, var_r[6:0]};
            if (!var_sel_r) begin var_r <= targ_cnt_r; var_sel_r <= 1'b1; end
            else begin
              off_r <= '0; scan_r <= '0; lit_r <= '0;
              if (base_cnt_r < CW'(bde_pkg::BLOCK_LEN)) begin
                slots_r <= '0; st_r <= E_SCAN;
              end else begin
                slots_r <= bde_pkg::SLOTS_MIN;
                cand_r  <= CW'(1) + (base_cnt_r - CW'(bde_pkg::BLOCK_LEN))
                           / CW'(bde_pkg::SAMPLE_STEP);
                st_r    <= E_CLR;
              end
            end
          end
        end
        E_CLR: begin
          if (slots_r < (cand_r << 1) && slots_r < CW'(bde_pkg::MAX_SLOTS))
            slots_r <= slots_r << 1;
          else begin
            h_r <= bde_pkg::FNV_OFFSET; bi_r <= '0; h_for_tgt_r <= 1'b0;
            st_r <= E_WIPE;
          end
        end
        // clear every one of the slots_r table slots, one per cycle
        E_WIPE: begin
          tab_mem[SW'(off_r)] <= '0;
          if (off_r == slots_r - 1'b1) begin
            off_r <= '0;
            st_r  <= (CW'(bde_pkg::BLOCK_LEN) <= base_cnt_r) ? E_BH_RD : E_SCAN;
          end else off_r <= off_r + 1'b1;
        end
        E_BH_RD, E_TH_RD: begin
          if (bi_r == BLW'(bde_pkg::BLOCK_LEN)) begin
            cur_h_r <= (h_r == '0) ? 32'd1 : h_r;
            h_r     <= (h_r == '0) ? 32'd1 : h_r;
            pi_r    <= '0;
            best_r  <= '0;
            st_r    <= h_for_tgt_r ? E_PR_RD : E_BINS_RD;
          end else begin
            base_rd_r <= base_mem[AW'(off_r + CW'(bi_r))];
            targ_rd_r <= targ_mem[TW'(scan_r + CW'(bi_r))];
            ret_r <= st_r;
            st_r  <= E_BH_ACC;
          end
        end
        E_BH_ACC: begin
          prod_r <= h_r ^ {24'd0, h_for_tgt_r ? targ_rd_r : base_rd_r};
          st_r   <= E_MULT;
        end
        E_MULT: begin
          h_r  <= prod_r * bde_pkg::FNV_PRIME;
          bi_r <= bi_r + 1'b1;
          st_r <= ret_r;
        end
        E_BINS_RD: begin
          if (pi_r == PLW'(bde_pkg::PROBE_LIMIT)) st_r <= E_BINS_CK;
          else begin
            tab_rd_r <= tab_mem[slot_idx];
            st_r <= E_BINS_WR;
          end
        end
        E_BINS_WR: begin
          if (tab_rd_r[44:13] == '0) begin
            tab_mem[slot_idx] <= {cur_h_r, 13'(off_r)};
            st_r <= E_BINS_CK;
          end else begin
            pi_r <= pi_r + 1'b1; st_r <= E_BINS_RD;
          end
        end
        E_BINS_CK: begin
          off_r <= off_r + CW'(bde_pkg::SAMPLE_STEP);
          h_r   <= bde_pkg::FNV_OFFSET; bi_r <= '0;
          st_r  <= (off_r + CW'(bde_pkg::SAMPLE_STEP + bde_pkg::BLOCK_LEN) <= base_cnt_r)
                   ? E_BH_RD : E_SCAN;
        end
        E_SCAN: begin
          if (scan_r >= targ_cnt_r) begin
            if (targ_cnt_r > lit_r) begin
              ins_end_r <= targ_cnt_r; ret_r <= E_TAIL; st_r <= E_INS_HD;
            end else st_r <= E_DONE;
          end else if (slots_r == '0 || scan_r + CW'(bde_pkg::BLOCK_LEN) > targ_cnt_r) begin
            scan_r <= scan_r + 1'b1;
          end else begin
            h_r <= bde_pkg::FNV_OFFSET; bi_r <= '0; h_for_tgt_r <= 1'b1; st_r <= E_TH_RD;
          end
        end
        E_PR_RD: begin
          if (pi_r == PLW'(bde_pkg::PROBE_LIMIT)) st_r <= E_DECIDE;
          else begin
            tab_rd_r <= tab_mem[slot_idx];
            st_r <= E_PR_CK;
          end
        end
        E_PR_CK: begin
          if (tab_rd_r[44:13] == '0) st_r <= E_DECIDE;
          else if (tab_rd_r[44:13] != cur_h_r ||
              CW'(tab_rd_r[12:0]) + CW'(bde_pkg::BLOCK_LEN) > base_cnt_r) begin
            pi_r <= pi_r + 1'b1; st_r <= E_PR_RD;
          end else begin
            len_r <= '0; off_r <= CW'(tab_rd_r[12:0]); st_r <= E_CMP_RD;
          end
        end
        E_CMP_RD: begin
          if (off_r + len_r < base_cnt_r && scan_r + len_r < targ_cnt_r) begin
            base_rd_r <= base_mem[AW'(off_r + len_r)];
            targ_rd_r <= targ_mem[TW'(scan_r + len_r)];
            st_r <= E_CMP_CK;
          end else begin
            if (len_r >= CW'(bde_pkg::BLOCK_LEN) && len_r > best_r) begin
              best_r <= len_r; best_off_r <= off_r;
            end
            pi_r <= pi_r + 1'b1; st_r <= E_PR_RD;
          end
        end
        E_CMP_CK: begin
          if (base_rd_r == targ_rd_r) begin len_r <= len_r + 1'b1; st_r <= E_CMP_RD; end
          else begin
            if (len_r >= CW'(bde_pkg::BLOCK_LEN) && len_r > best_r) begin
              best_r <= len_r; best_off_r <= off_r;
            end
            pi_r <= pi_r + 1'b1; st_r <= E_PR_RD;
          end
        end
        E_DECIDE: begin
          if (best_r == '0) begin scan_r <= scan_r + 1'b1; st_r <= E_SCAN; end
          else begin
            src_r <= best_off_r; run_r <= best_r;
            if (scan_r > lit_r) begin
              ins_end_r <= scan_r; ret_r <= E_CP_HD; st_r <= E_INS_HD;
            end else st_r <= E_CP_HD;
          end
        end
        E_INS_HD: begin
          if (lit_r >= ins_end_r) st_r <= ret_r;
          else begin
            ins_cnt_r <= (ins_end_r - lit_r > CW'(bde_pkg::INS_MAX)) ? bde_pkg::INS_MAX
                         : 7'(ins_end_r - lit_r);
            wr_en   <= 1'b1;
            wr_byte <= (ins_end_r - lit_r > CW'(bde_pkg::INS_MAX)) ? {1'b0, bde_pkg::INS_MAX}
                       : 8'(ins_end_r - lit_r);
            st_r <= E_INS_RD;
          end
        end
        E_INS_RD: begin
          if (ins_cnt_r == '0) st_r <= E_INS_HD;
          else begin
            targ_rd_r <= targ_mem[TW'(lit_r)];
            lit_r <= lit_r + 1'b1; ins_cnt_r <= ins_cnt_r - 1'b1;
            st_r <= E_INS_WR;
          end
        end
        E_INS_WR: begin
          wr_en <= 1'b1; wr_byte <= targ_rd_r; st_r <= E_INS_RD;
        end
        E_CP_HD: begin
          if (run_r == '0) begin
            scan_r <= scan_r + best_r; lit_r <= scan_r + best_r; st_r <= E_SCAN;
          end else begin
            logic [7:0] op;
            logic [2:0] n;
            op = 8'h80; n = '0;
            for (int i = 0; i < 2; i++) begin
              if (8'(src_r >> (8 * i)) != '0) begin
                op[i] = 1'b1; fld_r[n] <= 8'(src_r >> (8 * i)); n = n + 1'b1;
              end
            end
            if (chunk != bde_pkg::CHUNK_MAX) begin
              for (int i = 0; i < 2; i++) begin
                if (8'(chunk >> (8 * i)) != '0) begin
                  op[4 + i] = 1'b1; fld_r[n] <= 8'(chunk >> (8 * i)); n = n + 1'b1;
                end
              end
            end
            wr_en <= 1'b1; wr_byte <= op; fld_n_r <= n; fld_i_r <= '0;
            src_r <= src_r + CW'(chunk); run_r <= run_r - chunk;
            st_r <= E_CP_FLD;
          end
        end
        E_CP_FLD: begin
          if (fld_i_r == fld_n_r) st_r <= E_CP_HD;
          else begin
            wr_en <= 1'b1; wr_byte <= fld_r[fld_i_r]; fld_i_r <= fld_i_r + 1'b1;
          end
        end
        E_TAIL: st_r <= E_DONE;
        E_DONE: ;
        default: st_r <= E_IDLE;
      endcase
    end
  end

endmodule

[rtl/bde_ctrl.sv]
module bde_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        func,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_byte,
  output logic              out_final,
  output logic [1:0]        out_status,
  output bde_pkg::bde_cmd_t cmd,
  input  bde_pkg::bde_sts_t sts,
  input  logic [7:0]        rd_byte
);

  typedef enum logic [3:0] {
    C_LOAD = 4'b0001,
    C_ENC  = 4'b0010,
    C_OUT  = 4'b0100,
    C_RD   = 4'b1000
  } ctrl_state_t;

  ctrl_state_t st_r, st_nxt;
  logic        acc;
  logic        rd_last_r;

  // commands wait for the buffered byte to be read, for the result register and for the encoder
  assign in_tready = !out_tvalid && (st_r != C_ENC) && (st_r != C_RD) && !sts.enc_busy;
  assign acc = in_tvalid && in_tready;

  always_comb begin
    cmd = '0;
    st_nxt = st_r;
    if (acc) begin
      case (bde_pkg::func_t'(func))
        bde_pkg::FN_LOAD_BASE, bde_pkg::FN_LOAD_TARGET: begin
          cmd.clr_job   = (st_r != C_LOAD);
          cmd.ld_base   = (func == bde_pkg::FN_LOAD_BASE);
          cmd.ld_target = (func == bde_pkg::FN_LOAD_TARGET);
          st_nxt = C_LOAD;
        end
        bde_pkg::FN_FINISH: if (st_r == C_LOAD) begin
          cmd.enc_start = 1'b1; st_nxt = C_ENC;
        end
        bde_pkg::FN_PULL: if (!sts.overflow && st_r == C_OUT && sts.has_byte) begin
          cmd.pull = 1'b1; st_nxt = C_RD;
        end
        default: ;
      endcase
    end else if (st_r == C_ENC && !sts.enc_busy && !cmd.enc_start) begin
      st_nxt = C_OUT;
    end else if (st_r == C_RD) begin
      st_nxt = C_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= C_LOAD;
      out_tvalid <= 1'b0;
      rd_last_r  <= 1'b0;
    end else begin
      st_r <= (st_r == C_ENC && !acc) ? (sts.enc_busy ? C_ENC : C_OUT) : st_nxt;
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (st_r == C_RD) begin
        out_tvalid <= 1'b1; out_byte <= rd_byte; out_final <= rd_last_r;
        out_status <= bde_pkg::ST_VALID;
      end
      if (acc && bde_pkg::func_t'(func) == bde_pkg::FN_PULL) begin
        if (cmd.pull) rd_last_r <= sts.last_byte;
        else begin
          out_tvalid <= 1'b1; out_byte <= '0; out_final <= 1'b0;
          out_status <= sts.overflow ? bde_pkg::ST_OVERFLOW : bde_pkg::ST_EMPTY;
        end
      end
    end
  end

endmodule

[rtl/binary_delta_encoder.sv]
// Binary delta encoder.
// Input channel: one word per command. tuser carries func (0 load base byte,
// 1 load target byte, 2 finish and encode, 3 pull a delta byte); tdata
// carries the byte to load. Up to 4096 base and 4096 target bytes.
// Output channel: one word per pull. tdata = delta_byte, tlast = final byte,
// tuser = status (0 valid, 1 nothing left, 2 overflow).
// Loads are taken one per cycle while no output word waits. Finish starts
// the encoder, which walks the stores; tready stays low until it is done.
// With a base of a block or more the hash table has 1024..4096 slots. A pull
// of a buffered byte passes through the registered output buffer read and
// then the output register; a status-only pull goes straight to the latter.
// A stalled receiver holds the output register and tready drops until the
// word is taken. Reset (synchronous, rst_n low) empties counts and the
// output buffer; the hash table is cleared by a pass at each encode start whose base holds a block.
module binary_delta_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] delta_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [1:0] status
);

  bde_pkg::bde_cmd_t cmd;
  bde_pkg::bde_sts_t sts;
  logic [7:0]        rd_byte;

  bde_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .func(in_tuser),
    .out_tvalid, .out_tready, .out_byte(out_tdata), .out_final(out_tlast),
    .out_status(out_tuser), .cmd, .sts, .rd_byte
  );

  bde_datapath u_dp (
    .clk, .rst_n, .cmd, .data_byte(in_tdata), .sts, .rd_byte
  );

endmodule

[rtl/bde_checker.sv]
`include "binary_delta_encoder_defines.svh"

module bde_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [1:0] out_tuser
);

  `BDE_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BDE_ASSERT_IMP(a_no_take, out_tvalid, !in_tready)
  `BDE_ASSERT_IMP(a_status, out_tvalid, out_tuser != 2'd3)
  `BDE_ASSERT_IMP(a_quiet, out_tvalid && out_tuser != 2'd0, out_tdata == 8'd0 && !out_tlast)

endmodule

bind binary_delta_encoder bde_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready,
  .out_tdata, .out_tlast, .out_tuser
);

[tb/binary_delta_encoder_tb.sv]
module binary_delta_encoder_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bde_pkg::func_t fn;
    logic  [7:0]    data;
  } cmd_word_t;

  typedef struct {
    logic  [7:0]      delta;
    logic             last;
    bde_pkg::status_t st;
  } delta_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  binary_delta_encoder u_top (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

  always #2 clk = ~clk;

  cmd_word_t   cmd_q[$];
  delta_word_t delta_exp_q[$];
  int          n_errors = 0;
  int          n_cmds = 0;
  int          n_words = 0;
  int          n_jobs = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;

  // ---------------- encoder model ----------------
  logic [7:0]  base_m[bde_pkg::BASE_DEPTH];
  logic [7:0]  tgt_m[bde_pkg::TARGET_DEPTH];
  int unsigned nbase = 0, ntgt = 0;
  bit          slot_used_m[bde_pkg::MAX_SLOTS];
  int unsigned slot_hash_m[bde_pkg::MAX_SLOTS];
  int unsigned slot_off_m[bde_pkg::MAX_SLOTS];
  int unsigned nslots = 0;
  logic [7:0]  delta_buf[$];
  int unsigned pull_pos = 0;
  bit          out_phase = 1'b0;
  bit          ovf_m = 1'b0;

  function automatic void put_byte(int unsigned b);
    if (delta_buf.size() < bde_pkg::OUT_CAP) delta_buf.push_back(b[7:0]);
  endfunction

  function automatic void put_varint(int unsigned v);
    int unsigned b;
    b = v & 32'h7f;
    v = v >> 7;
    while (v != 0) begin
      put_byte(b | 32'h80);
      b = v & 32'h7f;
      v = v >> 7;
    end
    put_byte(b);
  endfunction

  function automatic void put_copy(int unsigned src, int unsigned run);
    int unsigned chunk, op, n, b;
    int unsigned fld[7];
    while (run > 0) begin
      chunk = (run > bde_pkg::CHUNK_MAX) ? bde_pkg::CHUNK_MAX : run;
      op = 32'h80;
      n = 0;
      for (int i = 0; i < 4; i++) begin
        b = (src >> (8 * i)) & 32'hff;
        if (b != 0) begin
          op |= 1 << i;
          fld[n++] = b;
        end
      end
      if (chunk != bde_pkg::CHUNK_MAX) begin
        for (int i = 0; i < 3; i++) begin
          b = (chunk >> (8 * i)) & 32'hff;
          if (b != 0) begin
            op |= 32'h10 << i;
            fld[n++] = b;
          end
        end
      end
      put_byte(op);
      for (int i = 0; i < n; i++) put_byte(fld[i]);
      src += chunk;
      run -= chunk;
    end
  endfunction

  function automatic void put_insert(int unsigned st, int unsigned en);
    int unsigned chunk;
    while (st < en) begin
      chunk = en - st;
      if (chunk > bde_pkg::INS_MAX) chunk = bde_pkg::INS_MAX;
      put_byte(chunk);
      for (int i = 0; i < chunk; i++) put_byte(tgt_m[(st + i) % bde_pkg::TARGET_DEPTH]);
      st += chunk;
    end
  endfunction

  function automatic int unsigned fnv_block(bit from_tgt, int unsigned st);
    int unsigned h;
    h = bde_pkg::FNV_OFFSET;
    for (int i = 0; i < bde_pkg::BLOCK_LEN; i++) begin
      h ^= {24'd0, from_tgt ? tgt_m[st + i] : base_m[st + i]};
      h = h * bde_pkg::FNV_PRIME;
    end
    return (h == 0) ? 1 : h;
  endfunction

  function automatic void build_slots();
    int unsigned blocks, h, s;
    nslots = 0;
    for (int i = 0; i < bde_pkg::MAX_SLOTS; i++) slot_used_m[i] = 1'b0;
    if (nbase < bde_pkg::BLOCK_LEN) return;
    blocks = 1 + (nbase - bde_pkg::BLOCK_LEN) / bde_pkg::SAMPLE_STEP;
    nslots = bde_pkg::SLOTS_MIN;
    while (nslots < blocks * 2 && nslots < bde_pkg::MAX_SLOTS) nslots *= 2;
    if (nslots > bde_pkg::MAX_SLOTS) nslots = bde_pkg::MAX_SLOTS;
    for (int unsigned off = 0; off + bde_pkg::BLOCK_LEN <= nbase;
         off += bde_pkg::SAMPLE_STEP) begin
      h = fnv_block(1'b0, off);
      for (int i = 0; i < bde_pkg::PROBE_LIMIT; i++) begin
        s = (h + i) & (nslots - 1);
        if (!slot_used_m[s]) begin
          slot_used_m[s] = 1'b1;
          slot_hash_m[s] = h;
          slot_off_m[s] = off;
          break;
        end
      end
    end
  endfunction

  function automatic int unsigned longest_match(int unsigned pos, output int unsigned src);
    int unsigned h, s, o, len, best, best_off;
    best = 0;
    best_off = 0;
    src = 0;
    if (nslots == 0 || pos + bde_pkg::BLOCK_LEN > ntgt) return 0;
    h = fnv_block(1'b1, pos);
    for (int i = 0; i < bde_pkg::PROBE_LIMIT; i++) begin
      s = (h + i) & (nslots - 1);
      if (!slot_used_m[s]) break;
      o = slot_off_m[s];
      if (slot_hash_m[s] != h || o + bde_pkg::BLOCK_LEN > nbase) continue;
      len = 0;
      while (o + len < nbase && pos + len < ntgt && base_m[o + len] == tgt_m[pos + len])
        len++;
      // a candidate not matching the whole first block is rejected
      if (len < bde_pkg::BLOCK_LEN) continue;
      if (len > best) begin
        best = len;
        best_off = o;
      end
    end
    if (best < bde_pkg::BLOCK_LEN) return 0;
    src = best_off;
    return best;
  endfunction

  function automatic void encode_delta();
    int unsigned pos, lit, src, run;
    pos = 0;
    lit = 0;
    delta_buf.delete();
    pull_pos = 0;
    put_varint(nbase);
    put_varint(ntgt);
    build_slots();
    while (pos < ntgt) begin
      run = longest_match(pos, src);
      if (run != 0) begin
        if (pos > lit) put_insert(lit, pos);
        put_copy(src, run);
        pos += run;
        lit = pos;
      end else begin
        pos++;
      end
    end
    if (ntgt > lit) put_insert(lit, ntgt);
  endfunction

  function automatic void apply_cmd(cmd_word_t c);
    delta_word_t w;
    if (c.fn == bde_pkg::FN_LOAD_BASE || c.fn == bde_pkg::FN_LOAD_TARGET) begin
      if (out_phase) begin
        nbase = 0;
        ntgt = 0;
        delta_buf.delete();
        pull_pos = 0;
        ovf_m = 1'b0;
        out_phase = 1'b0;
      end
      if (c.fn == bde_pkg::FN_LOAD_BASE) begin
        if (nbase < bde_pkg::BASE_DEPTH) base_m[nbase++] = c.data;
        else ovf_m = 1'b1;
      end else begin
        if (ntgt < bde_pkg::TARGET_DEPTH) tgt_m[ntgt++] = c.data;
        else ovf_m = 1'b1;
      end
    end else if (c.fn == bde_pkg::FN_FINISH) begin
      if (!out_phase) begin
        delta_buf.delete();
        pull_pos = 0;
        if (!ovf_m) encode_delta();
        out_phase = 1'b1;
      end
    end else begin
      w.delta = '0;
      w.last = 1'b0;
      if (ovf_m) begin
        w.st = bde_pkg::ST_OVERFLOW;
      end else if (out_phase && pull_pos < delta_buf.size()) begin
        w.delta = delta_buf[pull_pos];
        pull_pos++;
        w.last = (pull_pos == delta_buf.size());
        w.st = bde_pkg::ST_VALID;
      end else begin
        w.st = bde_pkg::ST_EMPTY;
      end
      delta_exp_q.push_back(w);
    end
  endfunction

  // ---------------- driver ----------------
  int in_gap = 0;

  always @(posedge clk) begin
    cmd_word_t c;
    logic      nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        c.fn = bde_pkg::func_t'(in_tuser);
        c.data = in_tdata;
        apply_cmd(c);
        n_cmds++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          in_tuser <= c.fn;
          in_tdata <= c.data;
          nv = 1'b1;
          if ($urandom_range(0, 63) == 0) calm_in = ~calm_in;
          in_gap <= calm_in ? 0 : $urandom_range(0, 15);
        end
      end
      in_tvalid <= nv;
    end
  end

  // ---------------- monitor ----------------
  int out_stall = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch word %0d: %s got %0h want %0h", n_words, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    delta_word_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (delta_exp_q.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, 0);
        end else begin
          w = delta_exp_q.pop_front();
          if (out_tuser !== w.st) report_mismatch("status", out_tuser, w.st);
          if (out_tdata !== w.delta) report_mismatch("delta_byte", out_tdata, w.delta);
          if (out_tlast !== w.last) report_mismatch("final_byte", out_tlast, w.last);
        end
        n_words++;
        if ($urandom_range(0, 63) == 0) calm_out = ~calm_out;
        out_stall <= calm_out ? 0 : $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic void push_cmd(bde_pkg::func_t fn, int unsigned d);
    cmd_word_t c;
    c.fn = fn;
    c.data = d[7:0];
    cmd_q.push_back(c);
  endfunction

  function automatic void push_pulls(int n);
    for (int i = 0; i < n; i++) push_cmd(bde_pkg::FN_PULL, $urandom());
  endfunction

  function automatic int unsigned rand_byte(bit narrow);
    return narrow ? $urandom_range(0, 3) : $urandom_range(0, 255);
  endfunction

  // Target is stitched from base slices (mostly aligned) and literal runs.
  function automatic void queue_job(int nb, int nt, bit mixed);
    logic [7:0] bs[$];
    logic [7:0] ts[$];
    bit         narrow;
    int         off, len, bi, ti;
    narrow = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < nb; i++) bs.push_back(8'(rand_byte(narrow)));
    while (ts.size() < nt) begin
      if (nb >= bde_pkg::BLOCK_LEN && $urandom_range(0, 2) != 0) begin
        off = $urandom_range(0, nb - bde_pkg::BLOCK_LEN);
        if ($urandom_range(0, 4) != 0) off = off - off % bde_pkg::SAMPLE_STEP;
        len = $urandom_range(bde_pkg::BLOCK_LEN - 2, nb - off);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) == 0) ts.push_back(8'($urandom()));
          else ts.push_back(bs[off + i]);
        end
      end else begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) ts.push_back(8'(rand_byte(narrow)));
      end
    end
    while (ts.size() > nt) void'(ts.pop_back());
    bi = 0;
    ti = 0;
    while (bi < nb || ti < nt) begin
      if (ti >= nt || (bi < nb && (!mixed || $urandom_range(0, 1) == 0))) begin
        push_cmd(bde_pkg::FN_LOAD_BASE, {24'd0, bs[bi++]});
      end else begin
        push_cmd(bde_pkg::FN_LOAD_TARGET, {24'd0, ts[ti++]});
      end
      if ($urandom_range(0, 199) == 0) push_pulls(1);
    end
    push_cmd(bde_pkg::FN_FINISH, $urandom());
    if ($urandom_range(0, 7) == 0) push_cmd(bde_pkg::FN_FINISH, $urandom());
    // sometimes the delta is abandoned partway through
    if ($urandom_range(0, 9) == 0) push_pulls($urandom_range(0, 6));
    else push_pulls(nt + nt / 100 + 8 + $urandom_range(0, 3));
    n_jobs++;
  endfunction

  initial begin
    // pull out of reset, finish on empty stores, pull past the end
    push_pulls(1);
    push_cmd(bde_pkg::FN_FINISH, 8'hff);
    push_cmd(bde_pkg::FN_FINISH, 8'h00);
    push_pulls(4);
    // load after finish starts a new job; base shorter than one block
    push_cmd(bde_pkg::FN_LOAD_BASE, 8'h00);
    push_cmd(bde_pkg::FN_LOAD_BASE, 8'hff);
    push_cmd(bde_pkg::FN_LOAD_TARGET, 8'hff);
    push_cmd(bde_pkg::FN_LOAD_TARGET, 8'h00);
    push_pulls(1);
    push_cmd(bde_pkg::FN_FINISH, 8'h55);
    push_pulls(8);
    // base past 256 bytes for two-byte offsets, then a short base
    queue_job(280, 32, 1'b0);
    queue_job(15, 30, 1'b0);
    while (cmd_q.size() < 700)
      queue_job($urandom_range(0, 48), $urandom_range(0, 32), $urandom_range(0, 1));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (cmd_q.size() == 0 && !in_tvalid);
    wait (delta_exp_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d jobs, %0d commands and %0d output words", n_jobs, n_cmds, n_words);
    if (n_errors == 0 && delta_exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d words still owed", n_errors, delta_exp_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d words owed", delta_exp_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/bde_pkg.sv
rtl/bde_datapath.sv
rtl/bde_ctrl.sv
rtl/binary_delta_encoder.sv
rtl/bde_checker.sv
tb/binary_delta_encoder_tb.sv
